### hdl/single_operand_alu_flags_macros.svh
// Assertion macros shared by the single-operand ALU RTL.
// Standalone header; used by files that carry concurrent checks.
`ifndef SINGLE_OPERAND_ALU_FLAGS_MACROS_SVH
`define SINGLE_OPERAND_ALU_FLAGS_MACROS_SVH

`ifndef SYNTHESIS

// Check sampled on the rising edge, switched off while reset is high.
`define SOAF_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("soaf check failed");

// Check sampled on the rising edge, also live during reset.
`define SOAF_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("soaf reset check failed");

`else

`define SOAF_ASSERT(lbl, clk, rst, prop)
`define SOAF_ASSERT_RST(lbl, clk, prop)

`endif

`endif

### hdl/soaf_pkg.sv
// Package for the single-operand ALU: command codes, item structs.
// No dependencies.
package soaf_pkg;

  typedef enum logic [3:0] {
    CMD_CLR  = 4'd0,
    CMD_COM  = 4'd1,
    CMD_INC  = 4'd2,
    CMD_DEC  = 4'd3,
    CMD_NEG  = 4'd4,
    CMD_TST  = 4'd5,
    CMD_ASR  = 4'd6,
    CMD_ASL  = 4'd7,
    CMD_ROR  = 4'd8,
    CMD_ROL  = 4'd9,
    CMD_SWAB = 4'd10,
    CMD_ADC  = 4'd11,
    CMD_SBC  = 4'd12,
    CMD_SXT  = 4'd13
  } cmd_t;

  localparam int unsigned WORD_W = 16;
  localparam int unsigned BYTE_W = 8;

  typedef struct packed {
    logic [3:0]        command;
    logic              byte_mode;
    logic [WORD_W-1:0] operand;
    logic              n;
    logic              z;
    logic              v;
    logic              c;
  } op_item_t;

  typedef struct packed {
    logic [WORD_W-1:0] result;
    logic              write_enable;
    logic              n;
    logic              z;
    logic              v;
    logic              c;
  } res_item_t;

endpackage

### hdl/soaf_in_stage.sv
// Input register stage: holds one accepted operand item.
// Depends on soaf_pkg.
module soaf_in_stage import soaf_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     up_valid,
  output logic     up_ready,
  input  op_item_t up_item,
  output logic     dn_valid,
  input  logic     dn_ready,
  output op_item_t dn_item
);

  logic     valid;
  op_item_t item;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= up_item;
    end
  end

endmodule

### hdl/soaf_exec.sv
// Combinational execute logic for the fourteen single-operand commands.
// Depends on soaf_pkg.
module soaf_exec import soaf_pkg::*; (
  input  op_item_t  op,
  output res_item_t res
);

  logic [WORD_W-1:0] mask;
  logic [WORD_W-1:0] sign;
  logic [WORD_W-1:0] maxpos;
  logic [WORD_W-1:0] dst;
  logic [WORD_W-1:0] r;
  logic [WORD_W-1:0] rm;
  logic [WORD_W-1:0] cin_w;
  logic              nz_from_r;
  logic              v;
  logic              c;
  logic              n;
  logic              z;
  logic              we;
  logic [WORD_W-1:0] full_r;

  always_comb begin
    mask   = op.byte_mode ? 16'h00FF : 16'hFFFF;
    sign   = op.byte_mode ? 16'h0080 : 16'h8000;
    maxpos = op.byte_mode ? 16'h007F : 16'h7FFF;
    dst    = op.operand & mask;
    cin_w  = {{(WORD_W-1){1'b0}}, op.c};
    r         = dst;
    nz_from_r = 1'b1;
    we        = 1'b1;
    v         = op.v;
    c         = op.c;
    n         = op.n;
    z         = op.z;
    full_r    = op.operand;

    unique case (op.command)
      CMD_CLR: begin
        r = '0; v = 1'b0; c = 1'b0;
      end
      CMD_COM: begin
        r = ~dst; v = 1'b0; c = 1'b1;
      end
      CMD_INC: begin
        r = dst + 16'd1; v = (dst == maxpos);
      end
      CMD_DEC: begin
        r = dst - 16'd1; v = (dst == sign);
      end
      CMD_NEG: begin
        r = 16'd0 - dst;
        v = ((r & mask) == sign);
        c = ((r & mask) != '0);
      end
      CMD_TST: begin
        we = 1'b0; v = 1'b0; c = 1'b0;
      end
      CMD_ASR: begin
        c = dst[0]; r = (dst >> 1) | (dst & sign);
      end
      CMD_ASL: begin
        c = |(dst & sign); r = dst << 1;
      end
      CMD_ROR: begin
        c = dst[0]; r = (dst >> 1) | (op.c ? sign : '0);
      end
      CMD_ROL: begin
        c = |(dst & sign); r = ((dst << 1) & mask) | cin_w;
      end
      CMD_SWAB: begin
        nz_from_r = 1'b0;
        full_r = {op.operand[BYTE_W-1:0], op.operand[WORD_W-1:BYTE_W]};
        n = op.operand[WORD_W-1];
        z = (op.operand[WORD_W-1:BYTE_W] == '0);
        v = 1'b0; c = 1'b0;
      end
      CMD_ADC: begin
        r = dst + cin_w;
        v = (dst == maxpos) && op.c;
        c = (dst == mask) && op.c;
      end
      CMD_SBC: begin
        r = dst - cin_w;
        v = (dst == sign);
        c = (dst == '0) && op.c;
      end
      CMD_SXT: begin
        nz_from_r = 1'b0;
        full_r = op.n ? 16'hFFFF : 16'h0000;
        z = !op.n; v = 1'b0;
      end
      default: begin
        // undefined codes: no operation, flags pass through
        nz_from_r = 1'b0;
        we = 1'b0;
      end
    endcase

    rm = r & mask;
    if (nz_from_r) begin
      n = |(rm & sign);
      z = (rm == '0);
      full_r = op.byte_mode ? {op.operand[WORD_W-1:BYTE_W], rm[BYTE_W-1:0]} : rm;
    end

    res.result       = full_r;
    res.write_enable = we;
    res.n            = n;
    res.z            = z;
    res.v            = v;
    res.c            = c;
  end

endmodule

### hdl/soaf_out_stage.sv
// Result register stage: holds one finished result item for the receiver.
// Depends on soaf_pkg.
module soaf_out_stage import soaf_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      up_valid,
  output logic      up_ready,
  input  res_item_t up_item,
  output logic      dn_valid,
  input  logic      dn_ready,
  output res_item_t dn_item
);

  logic      valid;
  res_item_t item;

  assign up_ready = !valid || dn_ready;
  assign dn_valid = valid;
  assign dn_item  = item;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      item <= up_item;
    end
  end

endmodule

### hdl/single_operand_alu_flags.sv
// Top level of the single-operand ALU execute unit.
// Depends on soaf_pkg, soaf_in_stage, soaf_exec, soaf_out_stage and the macro header.
//
// Usage:
//  - Input channel: in_valid/in_ready carry one item (command, byte_mode,
//    operand and the incoming N, Z, V, C flags). Accepted when both are high.
//  - Output channel: out_valid/out_ready carry one result item (result,
//    write_enable and the new flags) per input item, in order.
//  - Path: an accepted item sits in the input register, goes through the
//    execute logic and is captured in the result register, from which the
//    receiver takes it.
//  - Throughput: one item per cycle while out_ready is high, set by the single
//    pass through the execute logic between the input and result registers.
//  - Stall: each register refills whenever its contents move on, so a
//    stalled receiver holds the result register; the input register then
//    holds too and in_ready drops once both are full. Nothing is dropped.
//  - Reset (rst, synchronous, active high) empties both registers;
//    in_ready is high straight after reset.
//  - byte_mode works on the low byte and carries the high byte through;
//    swab and sxt always work on the whole word.
`include "single_operand_alu_flags_macros.svh"

module single_operand_alu_flags import soaf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [3:0]        command,
  input  logic              byte_mode,
  input  logic [WORD_W-1:0] operand,
  input  logic              n_in,
  input  logic              z_in,
  input  logic              v_in,
  input  logic              c_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] result,
  output logic              write_enable,
  output logic              n_out,
  output logic              z_out,
  output logic              v_out,
  output logic              c_out
);

  op_item_t  in_item;
  op_item_t  ex_item;     // operand item held in the input register
  logic      ex_valid;
  logic      ex_ready;    // result register can take the next result
  res_item_t ex_res;
  res_item_t out_item;

  // Gather the port fields into one item.
  assign in_item = '{command:   command,
                     byte_mode: byte_mode,
                     operand:   operand,
                     n:         n_in,
                     z:         z_in,
                     v:         v_in,
                     c:         c_in};

  soaf_in_stage u_in_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .up_item  (in_item),
    .dn_valid (ex_valid),
    .dn_ready (ex_ready),
    .dn_item  (ex_item)
  );

  // Single pass of execute logic between the two registers.
  soaf_exec u_exec (
    .op  (ex_item),
    .res (ex_res)
  );

  soaf_out_stage u_out_stage (
    .clk      (clk),
    .rst      (rst),
    .up_valid (ex_valid),
    .up_ready (ex_ready),
    .up_item  (ex_res),
    .dn_valid (out_valid),
    .dn_ready (out_ready),
    .dn_item  (out_item)
  );

  assign result       = out_item.result;
  assign write_enable = out_item.write_enable;
  assign n_out        = out_item.n;
  assign z_out        = out_item.z;
  assign v_out        = out_item.v;
  assign c_out        = out_item.c;

  // Both registers are empty straight after reset.
  `SOAF_ASSERT_RST(a_reset_empty, clk, rst |=> !out_valid && !ex_valid)
  // A held operand item must not change while the result register is full.
  `SOAF_ASSERT(a_ex_hold, clk, rst, ex_valid && !ex_ready |=> ex_valid && $stable(ex_item))
  // An operand item moving on always lands in the result register.
  `SOAF_ASSERT(a_ex_moves, clk, rst, ex_valid && ex_ready |=> out_valid)
  // Test never asks for a write back.
  `SOAF_ASSERT(a_tst_no_write, clk, rst, ex_valid && ex_item.command == CMD_TST |-> !ex_res.write_enable)

endmodule

### tb/tb_single_operand_alu_flags.sv
`timescale 1ns / 1ps
// Self-checking bench for single_operand_alu_flags: directed and random
// instructions, varied idling on both channels. Depends on soaf_pkg and the RTL.

module tb_single_operand_alu_flags;
  import soaf_pkg::*;

  // Codes the enum leaves out; the unit must treat them as no-ops.
  localparam logic [3:0] CMD_UNDEF_E = 4'd14;
  localparam logic [3:0] CMD_UNDEF_F = 4'd15;

  localparam int STALL_LIMIT = 3000; // cycles with no item moving on either side
  localparam int HOLD_LEN    = 300;  // long receiver hold-off, in cycles
  localparam int DRAIN_CYCLES = 10;  // idle margin before the final report

  logic clk = 1'b0;
  logic rst = 1'b1;

  // Input side
  logic     in_valid = 1'b0;
  logic     in_ready;
  op_item_t in_item  = '0;

  // Output side
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [WORD_W-1:0] result;
  logic              write_enable;
  logic              n_out, z_out, v_out, c_out;

  op_item_t  ops_to_send[$];   // items not yet offered
  res_item_t alu_results_due[$]; // predicted results, oldest first

  int  ops_queued   = 0;
  int  ops_accepted = 0;
  int  fail_count   = 0;
  int  send_idle_pct  = 0;
  int  recv_stall_pct = 0;
  int  hold_request   = 0;   // bumped by the sequencer to ask for a hold-off
  int  hold_granted   = 0;
  int  hold_left      = 0;
  int  quiet_cycles   = 0;
  logic in_took = 1'b0;

  single_operand_alu_flags u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .command     (in_item.command),
    .byte_mode   (in_item.byte_mode),
    .operand     (in_item.operand),
    .n_in        (in_item.n),
    .z_in        (in_item.z),
    .v_in        (in_item.v),
    .c_in        (in_item.c),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .result      (result),
    .write_enable(write_enable),
    .n_out       (n_out),
    .z_out       (z_out),
    .v_out       (v_out),
    .c_out       (c_out)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Behaviour of one instruction. In byte mode the sign sits at bit 7 and the
  // high byte of the operand passes through; swab, sxt and the undefined codes
  // always act on the whole word.
  function automatic res_item_t exec_single_op(op_item_t it);
    logic [WORD_W-1:0] mask, sign, maxpos, dst, r;
    logic n, z, v, c, we, whole_word, nz_from_r, old_c;
    res_item_t res;
    mask   = it.byte_mode ? 16'h00FF : 16'hFFFF;
    sign   = it.byte_mode ? 16'h0080 : 16'h8000;
    maxpos = it.byte_mode ? 16'h007F : 16'h7FFF;
    dst    = it.operand & mask;
    r      = dst;
    n = it.n; z = it.z; v = it.v; c = it.c;
    old_c      = it.c;
    we         = 1'b1;
    whole_word = 1'b0;
    nz_from_r  = 1'b1;
    case (it.command)
      CMD_CLR: begin
        r = '0; v = 1'b0; c = 1'b0;
      end
      CMD_COM: begin
        r = ~dst & mask; v = 1'b0; c = 1'b1;
      end
      CMD_INC: begin
        r = (dst + 16'd1) & mask; v = (dst == maxpos);
      end
      CMD_DEC: begin
        // carry is left alone
        r = (dst - 16'd1) & mask; v = (dst == sign);
      end
      CMD_NEG: begin
        r = (16'd0 - dst) & mask; v = (r == sign); c = (r != '0);
      end
      CMD_TST: begin
        we = 1'b0; v = 1'b0; c = 1'b0;
      end
      CMD_ASR: begin
        c = dst[0]; r = (dst >> 1) | (dst & sign);
      end
      CMD_ASL: begin
        c = ((dst & sign) != '0); r = (dst << 1) & mask;
      end
      CMD_ROR: begin
        c = dst[0]; r = (dst >> 1) | (old_c ? sign : 16'h0000);
      end
      CMD_ROL: begin
        c = ((dst & sign) != '0); r = ((dst << 1) & mask) | {15'd0, old_c};
      end
      CMD_SWAB: begin
        whole_word = 1'b1; nz_from_r = 1'b0;
        r = {it.operand[7:0], it.operand[15:8]};
        n = r[7]; z = (r[7:0] == 8'h00); v = 1'b0; c = 1'b0;
      end
      CMD_ADC: begin
        r = (dst + {15'd0, old_c}) & mask;
        v = (dst == maxpos) && old_c;
        c = (dst == mask) && old_c;
      end
      CMD_SBC: begin
        r = (dst - {15'd0, old_c}) & mask;
        v = (dst == sign);
        c = (dst == '0) && old_c;
      end
      CMD_SXT: begin
        // N passes through and drives the fill
        whole_word = 1'b1; nz_from_r = 1'b0;
        r = it.n ? 16'hFFFF : 16'h0000; z = ~it.n; v = 1'b0;
      end
      default: begin
        // undefined codes: nothing written, flags untouched
        whole_word = 1'b1; nz_from_r = 1'b0;
        r = it.operand; we = 1'b0;
      end
    endcase
    if (nz_from_r) begin
      n = ((r & sign) != '0);
      z = (r == '0);
    end
    if (!whole_word && it.byte_mode)
      r = {it.operand[15:8], r[7:0]};
    res.result       = r;
    res.write_enable = we;
    res.n = n; res.z = z; res.v = v; res.c = c;
    return res;
  endfunction

  task automatic check_field(input string name, input logic [WORD_W-1:0] want,
                             input logic [WORD_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
      fail_count++;
    end
  endtask

  // Drive side: a new item is put on the bus at the falling edge only once
  // the previous one has gone in (or nothing was offered).
  always @(negedge clk) begin
    op_item_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (ops_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = ops_to_send.pop_front();
        in_item  <= nxt;
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receive side: random stalls, plus a long hold-off on request so the
  // unit fills up and drops in_ready while items keep being offered.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else if (hold_request != hold_granted) begin
      hold_granted = hold_request;
      hold_left    = HOLD_LEN - 1;
      out_ready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // Handshakes are sampled at the rising edge: accepted items are predicted,
  // delivered results are checked against the oldest prediction.
  always @(posedge clk) begin
    res_item_t want, got;
    in_took <= !rst && in_valid && in_ready;
    if (!rst && in_valid && in_ready) begin
      alu_results_due.push_back(exec_single_op(in_item));
      ops_accepted++;
    end
    if (!rst && out_valid && out_ready) begin
      got.result = result;
      got.write_enable = write_enable;
      got.n = n_out; got.z = z_out; got.v = v_out; got.c = c_out;
      if (alu_results_due.size() == 0) begin
        $display("%0t: result %h with nothing expected", $time, got.result);
        fail_count++;
      end else begin
        want = alu_results_due.pop_front();
        check_field("result",       want.result,       got.result);
        check_field("write_enable", want.write_enable, got.write_enable);
        check_field("n",            want.n,            got.n);
        check_field("z",            want.z,            got.z);
        check_field("v",            want.v,            got.v);
        check_field("c",            want.c,            got.c);
      end
    end
  end

  // Watchdog: too long with no item moving on either channel ends the run.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("%0t: timeout, %0d still expected", $time, alu_results_due.size());
      $display("tb_single_operand_alu_flags NOT OK");
      $finish;
    end
  end

  task automatic add_op(input logic [3:0] cmd, input logic bm,
                        input logic [WORD_W-1:0] opnd, input logic [3:0] nzvc);
    op_item_t it;
    it.command   = cmd;
    it.byte_mode = bm;
    it.operand   = opnd;
    {it.n, it.z, it.v, it.c} = nzvc;
    ops_to_send.push_back(it);
    ops_queued++;
  endtask

  // Wait at falling edges, where the bench counters are stable.
  task automatic wait_drained();
    do @(negedge clk);
    while (ops_accepted != ops_queued || alu_results_due.size() != 0);
  endtask

  // Random operands lean towards the sign and carry boundaries.
  task automatic add_random_ops(input int count);
    logic [WORD_W-1:0] opnd;
    logic [7:0] hi, lo;
    for (int i = 0; i < count; i++) begin
      hi = 8'($urandom);
      case ($urandom_range(0, 3))
        0: lo = 8'h00;
        1: lo = 8'h7F;
        2: lo = 8'h80;
        default: lo = 8'hFF;
      endcase
      case ($urandom_range(0, 7))
        0: opnd = 16'h0000;
        1: opnd = 16'hFFFF;
        2: opnd = 16'h7FFF;
        3: opnd = 16'h8000;
        4: opnd = {hi, lo};
        5: opnd = {lo, hi};
        default: opnd = 16'($urandom);
      endcase
      add_op(4'($urandom_range(0, 15)), 1'($urandom), opnd, 4'($urandom));
    end
  endtask

  task automatic run_phase(input int count, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    add_random_ops(count);
    wait_drained();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: boundaries of every instruction, byte-mode high byte carried
    // through, tst leaving the operand, and the two undefined codes.
    add_op(CMD_CLR,  1'b0, 16'hFFFF, 4'b1111);
    add_op(CMD_COM,  1'b1, 16'h5A00, 4'b0000);
    add_op(CMD_INC,  1'b0, 16'h7FFF, 4'b0001);
    add_op(CMD_INC,  1'b1, 16'hAB7F, 4'b0000);
    add_op(CMD_INC,  1'b0, 16'hFFFF, 4'b0000);
    add_op(CMD_DEC,  1'b0, 16'h8000, 4'b0001);
    add_op(CMD_DEC,  1'b1, 16'h1280, 4'b0000);
    add_op(CMD_DEC,  1'b0, 16'h0000, 4'b0001);
    add_op(CMD_NEG,  1'b0, 16'h8000, 4'b0000);
    add_op(CMD_NEG,  1'b1, 16'hFF00, 4'b1111);
    add_op(CMD_TST,  1'b0, 16'h8000, 4'b0111);
    add_op(CMD_TST,  1'b1, 16'hFF00, 4'b1011);
    add_op(CMD_ASR,  1'b0, 16'h8001, 4'b0000);
    add_op(CMD_ASL,  1'b1, 16'hC0C0, 4'b0000);
    add_op(CMD_ROR,  1'b0, 16'h0001, 4'b0001);
    add_op(CMD_ROL,  1'b1, 16'h8080, 4'b0001);
    add_op(CMD_SWAB, 1'b1, 16'h00FF, 4'b0000);
    add_op(CMD_SWAB, 1'b0, 16'h8000, 4'b1111);
    add_op(CMD_ADC,  1'b0, 16'hFFFF, 4'b0001);
    add_op(CMD_ADC,  1'b1, 16'h007F, 4'b0001);
    add_op(CMD_SBC,  1'b0, 16'h0000, 4'b0001);
    add_op(CMD_SBC,  1'b1, 16'h3480, 4'b0000);
    add_op(CMD_SXT,  1'b0, 16'h1234, 4'b1001);
    add_op(CMD_SXT,  1'b1, 16'hFFFF, 4'b0110);
    add_op(CMD_UNDEF_E, 1'b0, 16'hBEEF, 4'b1010);
    add_op(CMD_UNDEF_F, 1'b1, 16'h0F0F, 4'b0101);
    wait_drained();

    run_phase(300, 0, 0);
    run_phase(200, 85, 0);
    run_phase(200, 0, 85);
    run_phase(220, 34, 34);

    // Back-pressure: receiver holds off while the sender keeps offering.
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    add_random_ops(100);
    @(posedge clk);
    hold_request++;
    wait_drained();

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && alu_results_due.size() == 0)
      $display("tb_single_operand_alu_flags OK");
    else
      $display("tb_single_operand_alu_flags NOT OK");
    $finish;
  end

endmodule
